/* rtl/touch_swipe_click_classifier_defines.svh */
// Assertion macros for the touch swipe/click classifier checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TOUCH_SWIPE_CLICK_CLASSIFIER_DEFINES_SVH
`define TOUCH_SWIPE_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tscc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tscc assertion failed");

`endif

/* rtl/tscc_pkg.sv */
// Shared constants and types for the touch swipe/click classifier.
// No dependencies; imported by the interfaces, the top level and the checker.
package tscc_pkg;

    localparam int EV_W           = 16;
    localparam int GEST_W         = 3;
    localparam int THR_W          = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [EV_W-1:0] EVT_KEY    = 16'd1;
    localparam logic [EV_W-1:0] EVT_ABS    = 16'd3;
    localparam logic [EV_W-1:0] CODE_X     = 16'd0;
    localparam logic [EV_W-1:0] CODE_Y     = 16'd1;
    localparam logic [EV_W-1:0] CODE_TOUCH = 16'd330;
    localparam logic [EV_W-1:0] VAL_PRESS  = 16'd1;
    localparam logic [EV_W-1:0] VAL_REL    = 16'd0;

    localparam logic [THR_W-1:0] THR_RESET = 16'd50;

    typedef logic [GEST_W-1:0] t_gesture;

    localparam t_gesture G_UP    = 3'd0;
    localparam t_gesture G_DOWN  = 3'd1;
    localparam t_gesture G_LEFT  = 3'd2;
    localparam t_gesture G_RIGHT = 3'd3;
    localparam t_gesture G_CLICK = 3'd4;

endpackage

/* rtl/tscc_if.sv */
// Channel interfaces: touch event input, gesture result output, threshold write.
// Depends on tscc_pkg.
interface tscc_ev_if;
    logic                     valid;
    logic                     ready;
    logic [tscc_pkg::EV_W-1:0] ev_type;
    logic [tscc_pkg::EV_W-1:0] ev_code;
    logic [tscc_pkg::EV_W-1:0] ev_value;
    modport source (output valid, ev_type, ev_code, ev_value, input ready);
    modport sink   (input valid, ev_type, ev_code, ev_value, output ready);
endinterface

interface tscc_res_if;
    logic                      valid;
    logic                      ready;
    tscc_pkg::t_gesture        gesture;
    logic [tscc_pkg::EV_W-1:0] click_x;
    logic [tscc_pkg::EV_W-1:0] click_y;
    modport source (output valid, gesture, click_x, click_y, input ready);
    modport sink   (input valid, gesture, click_x, click_y, output ready);
endinterface

interface tscc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tscc_pkg::THR_W-1:0] swipe_threshold;
    modport source (output valid, swipe_threshold, input ready);
    modport sink   (input valid, swipe_threshold, output ready);
endinterface

/* rtl/touch_swipe_click_classifier.sv */
// Touch swipe/click classifier top level: event decode, point latches, gesture result.
// Depends on tscc_pkg and the interfaces in tscc_if.sv.
//
//  channel | dir | payload                          | transaction when
//  --------+-----+----------------------------------+---------------------------
//  i_ev    | in  | ev_type, ev_code, ev_value       | valid & ready at i_clk rise
//  o_res   | out | gesture, click_x, click_y        | valid & ready at i_clk rise
//  i_cfg   | in  | swipe_threshold                  | valid & ready (ready is 1)
//
// One event per cycle sustained while o_res is not stalled; a result passes through the input
// register, then decode/compare into the result register.
// Events that give no result leave o_res untouched.
// Reset (i_rst_n low, synchronous) clears phase, all points and sets threshold 50.
// A stalled o_res holds the result; the input register still takes one event, then
// i_ev.ready drops until the result is taken.
module touch_swipe_click_classifier #(
    parameter int COORD_BITS = tscc_pkg::COORD_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tscc_ev_if.sink    i_ev,
    tscc_res_if.source o_res,
    tscc_cfg_if.sink   i_cfg
);
    import tscc_pkg::*;

    // delta width: room for the wider of coordinate and threshold plus sign
    localparam int DW = ((COORD_BITS > THR_W) ? COORD_BITS : THR_W) + 2;

    // input register
    logic            r_in_valid;
    logic [EV_W-1:0] r_type;
    logic [EV_W-1:0] r_code;
    logic [EV_W-1:0] r_val;

    // gesture state
    logic                  r_phase, n_phase;   // 0 waiting for press, 1 for release
    logic [COORD_BITS-1:0] r_start_x, n_start_x;
    logic [COORD_BITS-1:0] r_start_y, n_start_y;
    logic [COORD_BITS-1:0] r_end_x, n_end_x;
    logic [COORD_BITS-1:0] r_end_y, n_end_y;
    logic [COORD_BITS-1:0] r_report_x, n_report_x;
    logic [COORD_BITS-1:0] r_report_y, n_report_y;
    logic [THR_W-1:0]      r_thr;

    // result register
    logic            r_out_valid;
    t_gesture        r_gesture;
    logic [EV_W-1:0] r_click_x;
    logic [EV_W-1:0] r_click_y;

    logic                  proc_go;
    logic                  is_axis, is_touch, is_release;
    logic [COORD_BITS-1:0] cv;
    logic signed [DW-1:0]  dx, dy, thr_p, thr_n;
    logic                  has_res;
    t_gesture              gest;

    // stage 2 consumes the input register when the result register is free or draining
    assign proc_go     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_ev.ready  = !r_in_valid || proc_go;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid   = r_out_valid;
    assign o_res.gesture = r_gesture;
    assign o_res.click_x = r_click_x;
    assign o_res.click_y = r_click_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_ev.ready) begin
            r_in_valid <= i_ev.valid;
        end
        if (i_ev.ready && i_ev.valid) begin
            r_type <= i_ev.ev_type;
            r_code <= i_ev.ev_code;
            r_val  <= i_ev.ev_value;
        end
    end

    // decode
    assign is_axis    = (r_type == EVT_ABS) && ((r_code == CODE_X) || (r_code == CODE_Y));
    assign is_touch   = (r_type == EVT_KEY) && (r_code == CODE_TOUCH);
    assign is_release = is_touch && r_phase && (r_val == VAL_REL);
    assign cv         = COORD_BITS'(r_val);

    // movement against threshold
    assign dx    = $signed(DW'(r_end_x)) - $signed(DW'(r_start_x));
    assign dy    = $signed(DW'(r_end_y)) - $signed(DW'(r_start_y));
    assign thr_p = $signed(DW'(r_thr));
    assign thr_n = -thr_p;

    always_comb begin
        has_res = 1'b0;
        gest    = G_CLICK;
        if (is_release) begin
            if (r_end_x == '0) begin
                // no end X seen: treat as a tap at the report point
                has_res = 1'b1;
                gest    = G_CLICK;
            end else if (dx > thr_p) begin
                has_res = 1'b1;
                gest    = G_RIGHT;
            end else if (dx < thr_n) begin
                has_res = 1'b1;
                gest    = G_LEFT;
            end else if (dy > thr_p) begin
                has_res = 1'b1;
                gest    = G_DOWN;
            end else if (dy < thr_n) begin
                has_res = 1'b1;
                gest    = G_UP;
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        n_end_x    = r_end_x;
        n_end_y    = r_end_y;
        n_report_x = r_report_x;
        n_report_y = r_report_y;
        if (is_axis) begin
            if (!r_phase) begin
                // before press: start and report point follow the finger
                if (r_code == CODE_X) begin
                    n_start_x  = cv;
                    n_report_x = cv;
                end else begin
                    n_start_y  = cv;
                    n_report_y = cv;
                end
            end else if (r_code == CODE_X) begin
                n_end_x = cv;
            end else begin
                n_end_y = cv;
            end
        end else if (is_touch && !r_phase && (r_val == VAL_PRESS)) begin
            n_phase = 1'b1;
        end else if (is_release) begin
            // report point survives; everything else starts over
            n_phase   = 1'b0;
            n_start_x = '0;
            n_start_y = '0;
            n_end_x   = '0;
            n_end_y   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 1'b0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_end_x    <= '0;
            r_end_y    <= '0;
            r_report_x <= '0;
            r_report_y <= '0;
        end else if (proc_go) begin
            r_phase    <= n_phase;
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_end_x    <= n_end_x;
            r_end_y    <= n_end_y;
            r_report_x <= n_report_x;
            r_report_y <= n_report_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.swipe_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= has_res;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && has_res) begin
            r_gesture <= gest;
            if (gest == G_CLICK) begin
                r_click_x <= EV_W'(r_report_x);
                r_click_y <= EV_W'(r_report_y);
            end else begin
                r_click_x <= '0;
                r_click_y <= '0;
            end
        end
    end

endmodule

/* rtl/tscc_checker.sv */
// Port-level checker for the touch swipe/click classifier, bound to the top level.
// Depends on tscc_pkg and touch_swipe_click_classifier_defines.svh.
`include "touch_swipe_click_classifier_defines.svh"

module tscc_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_ev_ready,
    input logic                     i_res_valid,
    input logic                     i_res_ready,
    input tscc_pkg::t_gesture       i_gesture,
    input logic [tscc_pkg::EV_W-1:0] i_click_x,
    input logic [tscc_pkg::EV_W-1:0] i_click_y
);
    import tscc_pkg::*;

    // stalled result keeps its transaction
    `TSCC_ASSERT_NXT(a_res_hold, i_clk, i_rst_n,
        i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_gesture) && $stable(i_click_x) && $stable(i_click_y))

    // only the five gesture codes leave the block
    `TSCC_ASSERT_IMP(a_gest_code, i_clk, i_rst_n, i_res_valid,
        (i_gesture == G_UP) || (i_gesture == G_DOWN) || (i_gesture == G_LEFT) ||
        (i_gesture == G_RIGHT) || (i_gesture == G_CLICK))

    // swipes carry no point
    `TSCC_ASSERT_IMP(a_swipe_zero, i_clk, i_rst_n, i_res_valid && (i_gesture != G_CLICK),
        (i_click_x == '0) && (i_click_y == '0))

    // with no result pending the input side never stalls
    `TSCC_ASSERT_IMP(a_in_free, i_clk, i_rst_n, !i_res_valid, i_ev_ready)

endmodule

bind touch_swipe_click_classifier tscc_checker u_tscc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_ev_ready  (i_ev.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_gesture   (o_res.gesture),
    .i_click_x   (o_res.click_x),
    .i_click_y   (o_res.click_y)
);
